FILE: sv/ctsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctsc_pkg;

	typedef enum logic [1:0] {
		CMD_META   = 2'd0,
		CMD_HEADER = 2'd1,
		CMD_DATA   = 2'd2,
		CMD_DONE   = 2'd3
	} cmd_code_t;

	typedef enum logic [3:0] {
		ST_OPENED     = 4'd0,
		ST_REPLACED   = 4'd1,
		ST_NO_SLOT    = 4'd2,
		ST_IGNORED    = 4'd3,
		ST_HEADER_OK  = 4'd4,
		ST_STREAM_ERR = 4'd5,
		ST_BYTE_OK    = 4'd6,
		ST_READY      = 4'd7,
		ST_ABORTED    = 4'd8,
		ST_INCOMPLETE = 4'd9,
		ST_CRC_BAD    = 4'd10
	} status_t;

	typedef struct packed {
		cmd_code_t   cmd;
		logic [47:0] peer_mac;
		logic [31:0] file_id;
		logic [31:0] file_bytes;
		logic [15:0] chunk_count;
		logic [31:0] file_crc;
		logic [15:0] chunk_index;
		logic [15:0] chunk_len;
		logic [7:0]  data_byte;
		logic        done_complete;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [1:0]  session_slot;
		logic [7:0]  data_out;
		logic        data_valid;
		logic [15:0] chunks_seen;
		logic [31:0] bytes_seen;
	} result_t;

	// sequencing commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} ctl_cmd_t;

endpackage

`default_nettype wire

FILE: sv/ctsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ctsc_ctrl
	import ctsc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_stall,
	output logic          result_valid,
	input  wire logic     result_stall,
	output ctl_cmd_t      ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   item_stall_q;
	logic   result_valid_q;

	always_comb begin
		ctl.capture = item_valid && !item_stall_q;
		ctl.lookup  = (state_q == S_LOOK);
		ctl.commit  = (state_q == S_EXEC) && (!result_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			item_stall_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// show a committed result, drop it once taken
			result_valid_q <= ctl.commit || (result_valid_q && result_stall);
			case (state_q)
				S_IDLE: begin
					if (ctl.capture) begin
						state_q      <= S_LOOK;
						item_stall_q <= 1'b1;
					end
				end
				S_LOOK: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					// hold until the output register is free
					if (ctl.commit) begin
						state_q      <= S_IDLE;
						item_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q      <= S_IDLE;
					item_stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign item_stall   = item_stall_q;
	assign result_valid = result_valid_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> item_stall_q && state_q == S_LOOK)
		else $error("item accepted but block not busy");
	a_exec_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && result_valid_q && result_stall) |=> state_q == S_EXEC)
		else $error("execute left while output register full");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> result_valid_q && !item_stall_q)
		else $error("commit did not present a result");
`endif

endmodule

`default_nettype wire

FILE: sv/ctsc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ctsc_datapath
	import ctsc_pkg::*;
#(
	parameter int SESSIONS  = 4,
	parameter int MAX_CHUNK = 16384
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  ctl_cmd_t      ctl,
	input  item_t         item,
	output result_t       result
);

	localparam int SLOT_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

	function automatic logic [1:0] slot2(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+1:0] e;
		e = {2'b00, s};
		return e[1:0];
	endfunction

	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = ~crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		end
		return ~c;
	endfunction

	// slot register file
	logic [SESSIONS-1:0] active_q;
	logic [47:0]         sender_q   [SESSIONS];
	logic [31:0]         file_q     [SESSIONS];
	logic [31:0]         size_q     [SESSIONS];
	logic [15:0]         total_q    [SESSIONS];
	logic [15:0]         next_q     [SESSIONS];
	logic [31:0]         crc_exp_q  [SESSIONS];
	logic [31:0]         crc_run_q  [SESSIONS];
	logic [31:0]         bytes_q    [SESSIONS];
	logic [15:0]         due_q      [SESSIONS];

	item_t               item_q;
	result_t             result_q;

	logic [SESSIONS-1:0] match;
	logic                hit;
	logic [SLOT_W-1:0]   hit_idx;
	logic                free_ok;
	logic [SLOT_W-1:0]   free_idx;
	logic                hit_q;
	logic [SLOT_W-1:0]   hit_idx_q;
	logic                free_ok_q;
	logic [SLOT_W-1:0]   free_idx_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			item_q <= item;
		end
	end

	// sender lookup and lowest free slot
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = 0; i < SESSIONS; i++) begin
			match[i] = active_q[i] && (sender_q[i] == item_q.peer_mac);
		end
		for (int i = SESSIONS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (!active_q[i]) begin
				free_ok  = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.lookup) begin
			hit_q      <= hit;
			hit_idx_q  <= hit_idx;
			free_ok_q  <= free_ok;
			free_idx_q <= free_idx;
		end
	end

	// execute
	logic [31:0]       rd_file, rd_size, rd_crc_exp, rd_crc_run, rd_bytes;
	logic [15:0]       rd_total, rd_next, rd_due;
	logic              file_ok, hdr_err, complete;
	logic              wr_open, wr_hdr, wr_data, wr_drop;
	logic [SLOT_W-1:0] wr_idx;
	result_t           res;

	always_comb begin
		rd_file    = file_q[hit_idx_q];
		rd_size    = size_q[hit_idx_q];
		rd_total   = total_q[hit_idx_q];
		rd_next    = next_q[hit_idx_q];
		rd_crc_exp = crc_exp_q[hit_idx_q];
		rd_crc_run = crc_run_q[hit_idx_q];
		rd_bytes   = bytes_q[hit_idx_q];
		rd_due     = due_q[hit_idx_q];

		file_ok  = (rd_file == item_q.file_id);
		hdr_err  = (rd_due != 16'd0) || (item_q.chunk_index != rd_next) ||
			(({1'b0, rd_bytes} + 33'(item_q.chunk_len)) > {1'b0, rd_size}) ||
			(item_q.chunk_len > 16'(MAX_CHUNK));
		complete = item_q.done_complete && (rd_next == rd_total) && (rd_bytes == rd_size);

		wr_open = 1'b0;
		wr_hdr  = 1'b0;
		wr_data = 1'b0;
		wr_drop = 1'b0;
		wr_idx  = hit_idx_q;

		res.status       = ST_IGNORED;
		res.session_slot = slot2(hit_idx_q);
		res.data_out     = 8'd0;
		res.data_valid   = 1'b0;
		res.chunks_seen  = rd_next;
		res.bytes_seen   = rd_bytes;

		if (item_q.cmd == CMD_META) begin
			res.chunks_seen = 16'd0;
			res.bytes_seen  = 32'd0;
			if (hit_q) begin
				wr_open    = 1'b1;
				res.status = ST_REPLACED;
			end else if (free_ok_q) begin
				wr_open          = 1'b1;
				wr_idx           = free_idx_q;
				res.status       = ST_OPENED;
				res.session_slot = slot2(free_idx_q);
			end else begin
				res.status       = ST_NO_SLOT;
				res.session_slot = 2'd0;
			end
		end else if (!hit_q) begin
			res.session_slot = 2'd0;
			res.chunks_seen  = 16'd0;
			res.bytes_seen   = 32'd0;
		end else if (file_ok) begin
			case (item_q.cmd)
				CMD_HEADER: begin
					if (hdr_err) begin
						wr_drop    = 1'b1;
						res.status = ST_STREAM_ERR;
					end else begin
						wr_hdr          = 1'b1;
						res.status      = ST_HEADER_OK;
						res.chunks_seen = rd_next + 16'd1;
					end
				end
				CMD_DATA: begin
					// a stray byte with nothing due stays ignored
					if (rd_due != 16'd0) begin
						wr_data         = 1'b1;
						res.status      = ST_BYTE_OK;
						res.data_out    = item_q.data_byte;
						res.data_valid  = 1'b1;
						res.bytes_seen  = rd_bytes + 32'd1;
					end
				end
				CMD_DONE: begin
					wr_drop = 1'b1;
					if (complete && (rd_crc_run == rd_crc_exp)) begin
						res.status = ST_READY;
					end else if (!item_q.done_complete) begin
						res.status = ST_ABORTED;
					end else if (!complete) begin
						res.status = ST_INCOMPLETE;
					end else begin
						res.status = ST_CRC_BAD;
					end
				end
				default: begin
					res.status = ST_IGNORED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (ctl.commit) begin
			if (wr_open) begin
				active_q[wr_idx] <= 1'b1;
			end
			if (wr_drop) begin
				active_q[wr_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			result_q <= res;
			if (wr_open) begin
				sender_q[wr_idx]  <= item_q.peer_mac;
				file_q[wr_idx]    <= item_q.file_id;
				size_q[wr_idx]    <= item_q.file_bytes;
				total_q[wr_idx]   <= item_q.chunk_count;
				crc_exp_q[wr_idx] <= item_q.file_crc;
				next_q[wr_idx]    <= 16'd0;
				crc_run_q[wr_idx] <= 32'd0;
				bytes_q[wr_idx]   <= 32'd0;
				due_q[wr_idx]     <= 16'd0;
			end
			if (wr_hdr) begin
				next_q[wr_idx] <= rd_next + 16'd1;
				due_q[wr_idx]  <= item_q.chunk_len;
			end
			if (wr_data) begin
				crc_run_q[wr_idx] <= crc_step(rd_crc_run, item_q.data_byte);
				bytes_q[wr_idx]   <= rd_bytes + 32'd1;
				due_q[wr_idx]     <= rd_due - 16'd1;
			end
		end
	end

	assign result = result_q;

`ifndef SYNTHESIS
	a_unique_sender: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("sender open in more than one slot");
	a_byte_flag: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> (result_q.data_valid == (result_q.status == ST_BYTE_OK)))
		else $error("data_valid disagrees with status");
`endif

endmodule

`default_nettype wire

FILE: sv/chunked_transfer_session_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Chunked transfer session checker.
// Input channel (item_valid / item_stall / item): one word per command - meta opens
// a session for a sender, chunk header and data bytes advance it, done closes it.
// Output channel (result_valid / result_stall / result): exactly one result word per
// input word, in order; accepted data bytes come back on data_out with data_valid.
// The lookup / execute sequence reads and updates the shared slot register file in
// order: capture, sender compare across all slots, then checks, CRC-32 byte step
// and slot write; a new word is taken only after the previous one is written.
// item_stall is high while a word is in flight; the next word can be taken while
// the previous result still sits in the output register.
// If the receiver stalls, the finished result holds in the output register and the
// execute step waits, so the next word stays stalled until the result is taken.
// Reset (arst_n low) closes every session and empties the output register; slot
// contents other than the open flags are left as they are.
module chunked_transfer_session_checker
	import ctsc_pkg::*;
#(
	parameter int SESSIONS  = 4,
	parameter int MAX_CHUNK = 16384
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_stall,
	input  item_t     item,
	output logic      result_valid,
	input  wire logic result_stall,
	output result_t   result
);

	ctl_cmd_t ctl;

	// sequence capture, lookup and commit
	ctsc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ctl          (ctl)
	);

	// slot storage, sender match, chunk checks and CRC
	ctsc_datapath #(
		.SESSIONS  (SESSIONS),
		.MAX_CHUNK (MAX_CHUNK)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (item),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: tb/chunked_transfer_session_checker_tb.sv
`timescale 1ns / 1ps

module chunked_transfer_session_checker_tb;
	import ctsc_pkg::*;

	localparam int SESSIONS      = 4;
	localparam int MAX_CHUNK     = 16384;
	localparam int RANDOM_WORDS  = 520;
	localparam int LANES         = 3;
	localparam int LANE_DEPTH    = 48;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 80;
	localparam int CYCLE_LIMIT   = 100000;
	// file id shared by the noise words, so noise sessions can also be closed by noise
	localparam logic [31:0] NOISE_FILE = 32'hC0DE_0001;

	// ways a generated transfer can go wrong on purpose
	typedef enum int {
		FLAW_NONE,
		FLAW_CRC,
		FLAW_ABORT,
		FLAW_SHORT,
		FLAW_INDEX,
		FLAW_OVERRUN,
		FLAW_STRAY,
		FLAW_FOREIGN
	} flaw_t;

	// Session table mirror: predicts one result word per accepted input word and
	// holds the predictions in arrival order until the block returns them.
	class session_tracker #(int SLOTS = 4, int CHUNK_MAX = 16384);
		bit          open_flag[SLOTS];
		logic [47:0] sender[SLOTS];
		logic [31:0] file_tag[SLOTS];
		logic [31:0] size_total[SLOTS];
		logic [15:0] chunk_total[SLOTS];
		logic [15:0] next_chunk[SLOTS];
		logic [31:0] crc_want[SLOTS];
		logic [31:0] crc_run[SLOTS];
		logic [31:0] byte_count[SLOTS];
		logic [31:0] due[SLOTS];
		result_t     pending_results[$];
		int          status_hits[16];
		int          mismatches;
		int          checked;

		function new();
			mismatches = 0;
			checked = 0;
			foreach (open_flag[i]) begin
				open_flag[i] = 1'b0;
				due[i] = '0;
			end
			foreach (status_hits[i])
				status_hits[i] = 0;
		endfunction

		// reflected CRC-32, value inverted around each byte
		function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
			logic [31:0] c;
			c = ~crc ^ {24'h0, b};
			for (int k = 0; k < 8; k++)
				c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
			return ~c;
		endfunction

		function void note_word(item_t w);
			result_t     want;
			int          s;
			logic [32:0] reach;
			logic        whole;
			want = '0;
			want.status = ST_IGNORED;
			s = -1;
			for (int i = 0; i < SLOTS; i++)
				if (s < 0 && open_flag[i] && sender[i] == w.peer_mac)
					s = i;
			if (w.cmd == CMD_META) begin
				want.status = ST_REPLACED;
				if (s < 0) begin
					want.status = ST_OPENED;
					for (int i = 0; i < SLOTS; i++)
						if (s < 0 && !open_flag[i])
							s = i;
				end
				if (s < 0) begin
					want.status = ST_NO_SLOT;
				end else begin
					open_flag[s] = 1'b1;
					sender[s] = w.peer_mac;
					file_tag[s] = w.file_id;
					size_total[s] = w.file_bytes;
					chunk_total[s] = w.chunk_count;
					crc_want[s] = w.file_crc;
					next_chunk[s] = '0;
					crc_run[s] = '0;
					byte_count[s] = '0;
					due[s] = '0;
				end
			end else if (s >= 0 && file_tag[s] == w.file_id) begin
				case (w.cmd)
					CMD_HEADER: begin
						reach = {1'b0, byte_count[s]} + {17'd0, w.chunk_len};
						if (due[s] != 0 || w.chunk_index != next_chunk[s] ||
								reach > {1'b0, size_total[s]} || w.chunk_len > CHUNK_MAX) begin
							want.status = ST_STREAM_ERR;
							open_flag[s] = 1'b0;
							due[s] = '0;
						end else begin
							want.status = ST_HEADER_OK;
							next_chunk[s] = next_chunk[s] + 16'd1;
							due[s] = {16'd0, w.chunk_len};
						end
					end
					CMD_DATA: begin
						if (due[s] != 0) begin
							want.status = ST_BYTE_OK;
							want.data_out = w.data_byte;
							want.data_valid = 1'b1;
							crc_run[s] = crc_step(crc_run[s], w.data_byte);
							byte_count[s] = byte_count[s] + 32'd1;
							due[s] = due[s] - 32'd1;
						end
					end
					default: begin
						whole = w.done_complete && next_chunk[s] == chunk_total[s] &&
							byte_count[s] == size_total[s];
						if (whole && crc_run[s] == crc_want[s])
							want.status = ST_READY;
						else if (!w.done_complete)
							want.status = ST_ABORTED;
						else if (!whole)
							want.status = ST_INCOMPLETE;
						else
							want.status = ST_CRC_BAD;
						open_flag[s] = 1'b0;
						due[s] = '0;
					end
				endcase
			end
			if (s >= 0) begin
				want.session_slot = 2'(s);
				want.chunks_seen = next_chunk[s];
				want.bytes_seen = byte_count[s];
			end
			status_hits[int'(want.status)]++;
			pending_results.push_back(want);
		endfunction

		task report(string msg);
			$display("MISMATCH %s", msg);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d arrived with nothing outstanding (status %0d)",
					checked, got.status));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					report($sformatf("result %0d: status %0d, want %0d",
						checked, got.status, want.status));
				if (got.session_slot !== want.session_slot)
					report($sformatf("result %0d: session_slot %0d, want %0d",
						checked, got.session_slot, want.session_slot));
				if (got.data_out !== want.data_out)
					report($sformatf("result %0d: data_out %0h, want %0h",
						checked, got.data_out, want.data_out));
				if (got.data_valid !== want.data_valid)
					report($sformatf("result %0d: data_valid %0b, want %0b",
						checked, got.data_valid, want.data_valid));
				if (got.chunks_seen !== want.chunks_seen)
					report($sformatf("result %0d: chunks_seen %0d, want %0d",
						checked, got.chunks_seen, want.chunks_seen));
				if (got.bytes_seen !== want.bytes_seen)
					report($sformatf("result %0d: bytes_seen %0d, want %0d",
						checked, got.bytes_seen, want.bytes_seen));
			end
			checked++;
		endtask
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	session_tracker #(.SLOTS(SESSIONS), .CHUNK_MAX(MAX_CHUNK)) sb;

	// idle rates in percent, set per phase by the main sequence
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// receiver hold-off request, counted down by the receiver process
	int hold_left = 0;
	int cycle_count = 0;
	int words_sent = 0;

	// known senders: 0..5 belong to the transfer lanes (two per lane); noise draws from all eight
	logic [47:0] mac_pool[8];

	// each lane plays one well-formed (or deliberately flawed) transfer at a time
	item_t lane_words[LANES][LANE_DEPTH];
	int    lane_len[LANES];
	int    lane_pos[LANES];

	chunked_transfer_session_checker #(
		.SESSIONS (SESSIONS),
		.MAX_CHUNK(MAX_CHUNK)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop: a correct run, even under the slowest stall mix, needs only a
	// small fraction of this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: take a word whenever valid meets a low stall, then pick the
	// stall for the next edge. A requested hold-off forces stall high for its
	// whole length so the block backs up into its input.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && result_valid === 1'b1 && !result_stall)
				sb.check_result(result);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Fill every field, so bits that a command ignores still toggle.
	function automatic item_t random_word();
		item_t w;
		w.cmd = cmd_code_t'(2'($urandom_range(3)));
		w.peer_mac = {16'($urandom), $urandom};
		w.file_id = $urandom;
		w.file_bytes = $urandom;
		w.chunk_count = 16'($urandom);
		w.file_crc = $urandom;
		w.chunk_index = 16'($urandom);
		w.chunk_len = 16'($urandom);
		w.data_byte = 8'($urandom);
		w.done_complete = 1'($urandom);
		return w;
	endfunction

	function automatic item_t make_word(cmd_code_t c, logic [47:0] mac, logic [31:0] fid);
		item_t w;
		w = random_word();
		w.cmd = c;
		w.peer_mac = mac;
		w.file_id = fid;
		return w;
	endfunction

	// Noise mostly hits known senders. An unknown sender never opens a session,
	// otherwise stray sessions would pin the slots for the rest of the run.
	function automatic item_t noise_word();
		item_t w;
		w = random_word();
		if ($urandom_range(3) != 0)
			w.peer_mac = mac_pool[$urandom_range(7)];
		else if (w.cmd == CMD_META)
			w.cmd = CMD_DATA;
		if ($urandom_range(1) == 1)
			w.file_id = NOISE_FILE;
		if ($urandom_range(1) == 1) begin
			w.chunk_index = 16'($urandom_range(2));
			w.chunk_len = 16'($urandom_range(3));
		end
		return w;
	endfunction

	function automatic void add_lane_word(int lane, item_t w);
		lane_words[lane][lane_len[lane]] = w;
		lane_len[lane]++;
	endfunction

	// Build one transfer: meta, up to four chunks of up to seven bytes, done.
	// Slot 0 of the lane is reserved for the meta word, written last once the
	// size and CRC of the file are known.
	function automatic void build_transfer(int lane);
		item_t       w;
		flaw_t       flaw;
		int          n;
		int          len;
		int          bad_chunk;
		logic [47:0] mac;
		logic [31:0] fid;
		logic [31:0] bytes;
		logic [31:0] crc;
		mac = mac_pool[lane + LANES * $urandom_range(1)];
		fid = $urandom;
		n = $urandom_range(4);
		bad_chunk = (n > 0) ? $urandom_range(n - 1) : 0;
		flaw = FLAW_NONE;
		if ($urandom_range(99) >= 65)
			flaw = flaw_t'($urandom_range(FLAW_CRC, FLAW_FOREIGN));
		lane_len[lane] = 1;
		lane_pos[lane] = 0;
		bytes = '0;
		crc = '0;
		for (int k = 0; k < n; k++) begin
			// drop the last chunk but keep announcing it
			if (!(flaw == FLAW_SHORT && k == n - 1)) begin
				len = $urandom_range(7);
				w = make_word(CMD_HEADER, mac, fid);
				w.chunk_index = (flaw == FLAW_INDEX && k == bad_chunk) ? 16'(k + 1) : 16'(k);
				w.chunk_len = 16'(len);
				add_lane_word(lane, w);
				for (int j = 0; j < len; j++) begin
					w = make_word(CMD_DATA, mac, fid);
					crc = sb.crc_step(crc, w.data_byte);
					bytes = bytes + 32'd1;
					add_lane_word(lane, w);
				end
				if (flaw == FLAW_STRAY && k == bad_chunk)
					add_lane_word(lane, make_word(CMD_DATA, mac, fid));
			end
		end
		w = make_word(CMD_DONE, mac, fid);
		w.done_complete = (flaw != FLAW_ABORT);
		// a done with the wrong file id leaves the session open until replaced
		if (flaw == FLAW_FOREIGN)
			w.file_id = ~fid;
		add_lane_word(lane, w);
		w = make_word(CMD_META, mac, fid);
		w.file_bytes = (flaw == FLAW_OVERRUN && bytes > 0) ? bytes - 32'd1 : bytes;
		w.chunk_count = 16'(n);
		w.file_crc = (flaw == FLAW_CRC) ? crc ^ (32'd1 << $urandom_range(31)) : crc;
		lane_words[lane][0] = w;
	endfunction

	// Offer one word and hold it until accepted. Valid stays high from one word
	// to the next unless an idle gap is drawn.
	task automatic send_word(item_t w);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall !== 1'b0);
		sb.note_word(w);
		words_sent++;
	endtask

	// Drop valid and wait for every outstanding result, then let the pipe settle.
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_directed();
		item_t       w;
		logic [47:0] mac_a;
		logic [47:0] mac_b;
		logic [47:0] mac_c;
		logic [31:0] crc;
		mac_a = mac_pool[0];
		mac_b = mac_pool[1];
		mac_c = mac_pool[2];
		// no session yet: header and done are ignored
		send_word(make_word(CMD_HEADER, '1, '0));
		send_word(make_word(CMD_DONE, '0, '1));
		// fill all four slots, extremes of sender and sizes
		w = make_word(CMD_META, '0, '0);
		w.file_bytes = '1;
		w.chunk_count = '1;
		w.file_crc = '1;
		send_word(w);
		w = make_word(CMD_META, '1, '1);
		w.file_bytes = '1;
		w.chunk_count = '0;
		send_word(w);
		w = make_word(CMD_META, mac_a, 32'h1);
		w.file_bytes = '0;
		w.chunk_count = '0;
		send_word(w);
		w = make_word(CMD_META, mac_b, 32'h2);
		w.file_bytes = 32'd1;
		w.chunk_count = 16'd1;
		send_word(w);
		// table full: no slot for a new sender
		send_word(make_word(CMD_META, mac_c, 32'h3));
		// same sender again: replace in place
		w = make_word(CMD_META, '0, '0);
		w.file_bytes = '1;
		w.chunk_count = 16'd2;
		send_word(w);
		// wrong file id, then a byte with nothing due
		w = make_word(CMD_HEADER, '0, 32'h1);
		w.chunk_index = '0;
		w.chunk_len = 16'd1;
		send_word(w);
		w = make_word(CMD_DATA, '0, '0);
		w.data_byte = '1;
		send_word(w);
		// longest legal chunk, then a header while its bytes are still due
		w = make_word(CMD_HEADER, '0, '0);
		w.chunk_index = '0;
		w.chunk_len = 16'(MAX_CHUNK);
		send_word(w);
		w = make_word(CMD_HEADER, '0, '0);
		w.chunk_index = 16'd1;
		w.chunk_len = '0;
		send_word(w);
		// one past the chunk limit, bad index, size overrun
		w = make_word(CMD_HEADER, '1, '1);
		w.chunk_index = '0;
		w.chunk_len = 16'(MAX_CHUNK + 1);
		send_word(w);
		w = make_word(CMD_HEADER, mac_a, 32'h1);
		w.chunk_index = '1;
		w.chunk_len = '0;
		send_word(w);
		w = make_word(CMD_HEADER, mac_b, 32'h2);
		w.chunk_index = '0;
		w.chunk_len = 16'd2;
		send_word(w);
		send_word(make_word(CMD_DONE, '0, '0));
		// a short clean transfer, with a stray byte before the done
		crc = sb.crc_step(sb.crc_step(32'h0, 8'h00), 8'hFF);
		w = make_word(CMD_META, mac_c, 32'h3);
		w.file_bytes = 32'd2;
		w.chunk_count = 16'd1;
		w.file_crc = crc;
		send_word(w);
		w = make_word(CMD_HEADER, mac_c, 32'h3);
		w.chunk_index = '0;
		w.chunk_len = 16'd2;
		send_word(w);
		w = make_word(CMD_DATA, mac_c, 32'h3);
		w.data_byte = 8'h00;
		send_word(w);
		w = make_word(CMD_DATA, mac_c, 32'h3);
		w.data_byte = 8'hFF;
		send_word(w);
		send_word(make_word(CMD_DATA, mac_c, 32'h3));
		w = make_word(CMD_DONE, mac_c, 32'h3);
		w.done_complete = 1'b1;
		send_word(w);
		// widest chunk length, then a sender abort
		w = make_word(CMD_META, mac_a, '1);
		w.file_bytes = '0;
		send_word(w);
		w = make_word(CMD_HEADER, mac_a, '1);
		w.chunk_index = '0;
		w.chunk_len = '1;
		send_word(w);
		w = make_word(CMD_META, mac_b, '0);
		w.file_bytes = '0;
		w.chunk_count = '0;
		send_word(w);
		w = make_word(CMD_DONE, mac_b, '0);
		w.done_complete = 1'b0;
		send_word(w);
	endtask

	// Mostly interleaved lane transfers with random content, about a tenth noise.
	task automatic run_random(int count);
		int lane;
		repeat (count) begin
			if ($urandom_range(99) < 10) begin
				send_word(noise_word());
			end else begin
				lane = $urandom_range(LANES - 1);
				if (lane_pos[lane] >= lane_len[lane])
					build_transfer(lane);
				send_word(lane_words[lane][lane_pos[lane]]);
				lane_pos[lane]++;
			end
		end
	endtask

	initial begin
		int phase;
		sb = new();
		for (int i = 0; i < 8; i++) begin
			mac_pool[i] = {16'($urandom), $urandom};
			// keep the pool distinct
			mac_pool[i][7:0] = 8'(i);
		end
		for (int i = 0; i < LANES; i++) begin
			lane_len[i] = 0;
			lane_pos[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain();

		// Phase 0: slow receiver. Phase 1: slow sender. Phase 2: full rate.
		// Halfway through each, hold the receiver off long enough to back the
		// block up, and pause the sender until everything is back at the end.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 22;
					recv_idle_pct = 70;
				end
				1: begin
					send_idle_pct = 70;
					recv_idle_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			run_random(RANDOM_WORDS / 6);
			hold_left = HOLD_CYCLES;
			run_random(RANDOM_WORDS / 6);
			drain();
		end

		$display("Drove %0d words (directed corners, three stall mixes), checked %0d",
			words_sent, sb.checked);
		$display("opened %0d/%0d no-slot %0d errors %0d, done %0d/%0d/%0d/%0d",
			sb.status_hits[ST_OPENED], sb.status_hits[ST_REPLACED],
			sb.status_hits[ST_NO_SLOT], sb.status_hits[ST_STREAM_ERR],
			sb.status_hits[ST_READY], sb.status_hits[ST_ABORTED],
			sb.status_hits[ST_INCOMPLETE], sb.status_hits[ST_CRC_BAD]);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
